[hdl/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define UCSK_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define UCSK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ucsk_pkg.sv]
// Types, constants and mapping functions of the UTF-8 skeleton mapper.
package ucsk_pkg;

  localparam int CP_W    = 21;
  localparam int MAX_RES = 4;
  localparam int QDEPTH  = 8;
  localparam int QAW     = 3;
  localparam int QCW     = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_name;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       invalid;
  } result_t;

  // Results caused by one input byte, slot 0 first.
  typedef struct packed {
    logic [2:0]                 count;
    result_t [MAX_RES-1:0]      ent;
  } group_t;

  function automatic logic [7:0] map_ascii(input logic [6:0] c);
    logic [7:0] r;
    r = {1'b0, c};
    unique case (c)
      7'h30: r = 8'h6F;
      7'h31: r = 8'h6C;
      7'h32: r = 8'h7A;
      7'h35: r = 8'h73;
      7'h36: r = 8'h67;
      7'h38: r = 8'h62;
      default: begin
        if (c >= 7'h41 && c <= 7'h5A) begin
          r = {1'b0, c} + 8'h20;
        end
      end
    endcase
    return r;
  endfunction

  // Non-ASCII lookalikes; zero means no entry.
  function automatic logic [7:0] map_wide(input logic [CP_W-1:0] cp);
    logic [7:0] r;
    r = 8'h00;
    if (cp >= 21'h0FF21 && cp <= 21'h0FF3A) begin
      r = 8'h61 + (cp[7:0] - 8'h21);
    end else if (cp >= 21'h0FF41 && cp <= 21'h0FF5A) begin
      r = 8'h61 + (cp[7:0] - 8'h41);
    end else begin
      unique case (cp)
        21'h0430, 21'h0410, 21'h0391, 21'h03B1: r = 8'h61;
        21'h0432, 21'h0412, 21'h0392, 21'h03B2: r = 8'h62;
        21'h0441, 21'h0421:                     r = 8'h63;
        21'h0435, 21'h0415, 21'h0395, 21'h03B5: r = 8'h65;
        21'h043D, 21'h041D, 21'h0397, 21'h03B7: r = 8'h68;
        21'h0456, 21'h0406, 21'h0399, 21'h03B9: r = 8'h69;
        21'h0458, 21'h0408:                     r = 8'h6A;
        21'h043A, 21'h041A, 21'h039A, 21'h03BA: r = 8'h6B;
        21'h043C, 21'h041C, 21'h039C, 21'h03BC: r = 8'h6D;
        21'h039D, 21'h03BD:                     r = 8'h6E;
        21'h043E, 21'h041E, 21'h039F, 21'h03BF: r = 8'h6F;
        21'h0440, 21'h0420, 21'h03A1, 21'h03C1: r = 8'h70;
        21'h0442, 21'h0422, 21'h03A4, 21'h03C4: r = 8'h74;
        21'h0445, 21'h0425, 21'h03A7, 21'h03C7: r = 8'h78;
        21'h0443, 21'h0423, 21'h03A5, 21'h03C5: r = 8'h79;
        21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014,
        21'h2212, 21'h0FF0D:                    r = 8'h2D;
        default:                                r = 8'h00;
      endcase
    end
    return r;
  endfunction

  // Skeleton bytes of one finished code point.
  function automatic group_t emit_cp(input logic [CP_W-1:0] cp, input logic fin);
    group_t     g;
    logic [7:0] m;
    g = '0;
    m = map_wide(cp);
    if (cp <= 21'h7F) begin
      g.count           = 3'd1;
      g.ent[0].out_byte = map_ascii(cp[6:0]);
      g.ent[0].last     = fin;
    end else if (m != 8'h00) begin
      g.count           = 3'd1;
      g.ent[0].out_byte = m;
      g.ent[0].last     = fin;
    end else if (cp <= 21'h7FF) begin
      g.count           = 3'd2;
      g.ent[0].out_byte = {3'b110, cp[10:6]};
      g.ent[1].out_byte = {2'b10, cp[5:0]};
      g.ent[1].last     = fin;
    end else if (cp <= 21'hFFFF) begin
      g.count           = 3'd3;
      g.ent[0].out_byte = {4'b1110, cp[15:12]};
      g.ent[1].out_byte = {2'b10, cp[11:6]};
      g.ent[2].out_byte = {2'b10, cp[5:0]};
      g.ent[2].last     = fin;
    end else begin
      g.count           = 3'd4;
      g.ent[0].out_byte = {5'b11110, cp[20:18]};
      g.ent[1].out_byte = {2'b10, cp[17:12]};
      g.ent[2].out_byte = {2'b10, cp[11:6]};
      g.ent[3].out_byte = {2'b10, cp[5:0]};
      g.ent[3].last     = fin;
    end
    return g;
  endfunction

endpackage

[hdl/ucsk_decode.sv]
// Input register, UTF-8 decoder state and lookalike mapping.
module ucsk_decode import ucsk_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_stall,
  input  item_t  item,
  input  logic   space_ok,
  output group_t grp
);

  logic            in_v;
  item_t           in_r;
  logic [CP_W-1:0] accum, accum_next;
  logic [1:0]      pending, pending_next;
  logic            err, err_next;
  logic            adv;

  assign item_stall = in_v && !space_ok;
  assign adv        = in_v && space_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (!item_stall) begin
      in_v <= item_valid;
    end
    if (!item_stall) begin
      in_r <= item;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic       done;
    logic       fin;
    b            = in_r.in_byte;
    fin          = in_r.end_of_name;
    done         = 1'b0;
    accum_next   = accum;
    pending_next = pending;
    err_next     = err;
    grp          = '0;
    if (!err) begin
      if (pending == 2'd0) begin
        priority if (b[7] == 1'b0) begin
          accum_next = {13'd0, b};
          done       = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          accum_next   = {16'd0, b[4:0]};
          pending_next = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          accum_next   = {17'd0, b[3:0]};
          pending_next = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          accum_next   = {18'd0, b[2:0]};
          pending_next = 2'd3;
        end else begin
          err_next = 1'b1;
        end
      end else if (b[7:6] == 2'b10) begin
        accum_next   = {accum[CP_W-7:0], b[5:0]};
        pending_next = pending - 2'd1;
        done         = (pending == 2'd1);
      end else begin
        err_next = 1'b1;
      end
    end
    if (done) begin
      grp = emit_cp(accum_next, fin);
    end
    if (fin) begin
      if (err_next || pending_next != 2'd0) begin
        grp                = '0;
        grp.count          = 3'd1;
        grp.ent[0].last    = 1'b1;
        grp.ent[0].invalid = 1'b1;
      end
      accum_next   = '0;
      pending_next = 2'd0;
      err_next     = 1'b0;
    end
    if (!adv) begin
      grp = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum   <= '0;
      pending <= 2'd0;
      err     <= 1'b0;
    end else if (adv) begin
      accum   <= accum_next;
      pending <= pending_next;
      err     <= err_next;
    end
  end

endmodule

[hdl/ucsk_outq.sv]
// Result queue: takes up to four results a cycle, hands out one unless stalled.
module ucsk_outq import ucsk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  group_t  grp,
  output logic    space_ok,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  result_t        mem [QDEPTH];
  logic [QAW-1:0] head, tail;
  logic [QCW-1:0] count;
  logic           pop;

  assign result_valid = (count != '0);
  assign result       = mem[head];
  assign pop          = result_valid && !result_stall;
  assign space_ok     = (count <= QCW'(QDEPTH - MAX_RES));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + QAW'(1);
      end
      tail  <= tail + QAW'(grp.count);
      count <= count + QCW'(grp.count) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (3'(k) < grp.count) begin
        mem[tail + QAW'(k)] <= grp.ent[k];
      end
    end
  end

endmodule

[hdl/utf8_confusable_skeleton_mapper_unit.sv]
// Top level of the UTF-8 confusable skeleton mapper.
//
// Feed the UTF-8 bytes of one identifier, one byte per transaction, and
// mark the final byte with end_of_name. Each finished code point is mapped
// to its skeleton: lookalike Latin, Cyrillic, Greek and fullwidth letters,
// some digits and dashes become one ASCII byte, other ASCII is lowercased,
// and everything else comes back in shortest-form UTF-8, one byte per
// result transaction. A malformed or truncated sequence drops the rest of
// the identifier and gives a single result with out_byte 0, last and
// invalid set on the final byte; bytes sent earlier for that identifier
// must be discarded. The block takes one input byte per cycle when not
// stalled: a byte is held in the input register, where decode and
// mapping are done, and its results are registered into an eight-entry
// queue that drains one result a cycle while the receiver does not stall.
// A four byte code point comes out as a burst of four; since a code point
// never yields more bytes than it took in, one byte a cycle is sustained
// while the receiver does not stall. Input stalls only while the queue
// holds more than four results, that is while the output side is held off.
module utf8_confusable_skeleton_mapper_unit import ucsk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  group_t grp;
  logic   space_ok;

  // Decode and map the registered byte; advance only with queue room.
  ucsk_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .space_ok   (space_ok),
    .grp        (grp)
  );

  // Hold results until the receiver takes them, oldest first.
  ucsk_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .grp          (grp),
    .space_ok     (space_ok),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[hdl/ucsk_checker.sv]
// Port-level checks of the skeleton mapper, bound to its top level.
`include "assert_macros.svh"

module ucsk_checker import ucsk_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  logic res_bad;
  logic inv_shape_ok;
  logic res_held;
  logic item_held;

  assign res_bad      = result_valid && result.invalid;
  assign inv_shape_ok = result.last && (result.out_byte == 8'h00);
  assign res_held     = result_valid && result_stall;
  assign item_held    = item_valid && item_stall;

  // An invalid result closes the identifier and carries no byte.
  `UCSK_ASSERT_IMPL(a_inv_closes, res_bad, inv_shape_ok, "bad invalid result")

  // Input only backs up while results are waiting.
  `UCSK_ASSERT_IMPL(a_stall_needs_backlog, item_stall, result_valid, "stall without backlog")

  // A stalled result holds.
  `UCSK_ASSERT_NEXT(a_res_holds, res_held, result_valid && $stable(result), "result changed")

  // A stalled input transaction holds.
  `UCSK_ASSERT_NEXT(a_item_holds, item_held, item_valid && $stable(item), "item changed")

endmodule

bind utf8_confusable_skeleton_mapper_unit ucsk_checker u_ucsk_checker (.*);

[dv/tb_utf8_confusable_skeleton_mapper_unit.sv]
// Self-checking testbench for the UTF-8 confusable skeleton mapper.
import ucsk_pkg::*;

class skeleton_scoreboard;
  logic [20:0] accum     = '0;
  logic [1:0]  cont_left = '0;
  logic        poisoned  = 1'b0;
  result_t     expected_skeleton[$];
  int          errors    = 0;

  function void clear_decoder();
    accum     = '0;
    cont_left = '0;
    poisoned  = 1'b0;
  endfunction

  function logic [7:0] fold_ascii(logic [6:0] c);
    case (c)
      7'h30:   return "o";
      7'h31:   return "l";
      7'h32:   return "z";
      7'h35:   return "s";
      7'h36:   return "g";
      7'h38:   return "b";
      default: return (c >= 7'h41 && c <= 7'h5A) ? {1'b0, c} + 8'h20 : {1'b0, c};
    endcase
  endfunction

  // Zero means the code point has no single-byte lookalike.
  function logic [7:0] lookalike(logic [20:0] cp);
    if (cp >= 21'h0FF21 && cp <= 21'h0FF3A) return 8'h61 + 8'(cp - 21'h0FF21);
    if (cp >= 21'h0FF41 && cp <= 21'h0FF5A) return 8'h61 + 8'(cp - 21'h0FF41);
    case (cp)
      21'h0430, 21'h0410, 21'h0391, 21'h03B1: return "a";
      21'h0432, 21'h0412, 21'h0392, 21'h03B2: return "b";
      21'h0441, 21'h0421:                     return "c";
      21'h0435, 21'h0415, 21'h0395, 21'h03B5: return "e";
      21'h043D, 21'h041D, 21'h0397, 21'h03B7: return "h";
      21'h0456, 21'h0406, 21'h0399, 21'h03B9: return "i";
      21'h0458, 21'h0408:                     return "j";
      21'h043A, 21'h041A, 21'h039A, 21'h03BA: return "k";
      21'h043C, 21'h041C, 21'h039C, 21'h03BC: return "m";
      21'h039D, 21'h03BD:                     return "n";
      21'h043E, 21'h041E, 21'h039F, 21'h03BF: return "o";
      21'h0440, 21'h0420, 21'h03A1, 21'h03C1: return "p";
      21'h0442, 21'h0422, 21'h03A4, 21'h03C4: return "t";
      21'h0445, 21'h0425, 21'h03A7, 21'h03C7: return "x";
      21'h0443, 21'h0423, 21'h03A5, 21'h03C5: return "y";
      21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014,
      21'h2212, 21'h0FF0D:                    return "-";
      default:                                return 8'h00;
    endcase
  endfunction

  function void add_byte(logic [7:0] b, logic lst, logic bad);
    result_t r;
    r.out_byte = b;
    r.last     = lst;
    r.invalid  = bad;
    expected_skeleton.insert(expected_skeleton.size(), r);
  endfunction

  // Expect the skeleton of one finished code point, shortest form if unmapped.
  function void expect_code_point(logic [20:0] cp, logic fin);
    logic [7:0] alias_b;
    alias_b = lookalike(cp);
    if (cp <= 21'h7F) begin
      add_byte(fold_ascii(cp[6:0]), fin, 1'b0);
    end else if (alias_b != 8'h00) begin
      add_byte(alias_b, fin, 1'b0);
    end else if (cp <= 21'h7FF) begin
      add_byte({3'b110, cp[10:6]}, 1'b0, 1'b0);
      add_byte({2'b10, cp[5:0]}, fin, 1'b0);
    end else if (cp <= 21'hFFFF) begin
      add_byte({4'b1110, cp[15:12]}, 1'b0, 1'b0);
      add_byte({2'b10, cp[11:6]}, 1'b0, 1'b0);
      add_byte({2'b10, cp[5:0]}, fin, 1'b0);
    end else begin
      add_byte({5'b11110, cp[20:18]}, 1'b0, 1'b0);
      add_byte({2'b10, cp[17:12]}, 1'b0, 1'b0);
      add_byte({2'b10, cp[11:6]}, 1'b0, 1'b0);
      add_byte({2'b10, cp[5:0]}, fin, 1'b0);
    end
  endfunction

  // Decode one accepted byte; return 1 unless the byte was simply dropped.
  function bit note_byte(item_t it);
    logic [7:0] b;
    logic       finished;
    bit         was_live;
    b        = it.in_byte;
    finished = 1'b0;
    was_live = !poisoned;
    if (!poisoned) begin
      if (cont_left == 2'd0) begin
        if (!b[7]) begin
          accum    = {14'b0, b[6:0]};
          finished = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          accum     = {16'b0, b[4:0]};
          cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          accum     = {17'b0, b[3:0]};
          cont_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          accum     = {18'b0, b[2:0]};
          cont_left = 2'd3;
        end else begin
          poisoned = 1'b1;
        end
      end else if (b[7:6] == 2'b10) begin
        accum     = {accum[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        finished  = (cont_left == 2'd0);
      end else begin
        poisoned = 1'b1;
      end
    end
    if (it.end_of_name && (poisoned || cont_left != 2'd0)) begin
      add_byte(8'h00, 1'b1, 1'b1);
    end else if (finished) begin
      expect_code_point(accum, it.end_of_name);
    end
    if (it.end_of_name) begin
      clear_decoder();
    end
    return was_live || it.end_of_name;
  endfunction

  function void report_field(string field, logic [7:0] want, logic [7:0] got,
                             longint unsigned stamp);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h actual %h", stamp, field, want, got);
    end
  endfunction

  function void check_result(result_t got, longint unsigned stamp);
    result_t want;
    if (expected_skeleton.size() == 0) begin
      errors++;
      $display("%0t: result %h with nothing expected (expected none, actual %h)",
               stamp, got, got);
      return;
    end
    want = expected_skeleton.pop_front();
    report_field("out_byte", want.out_byte, got.out_byte, stamp);
    report_field("last", {7'b0, want.last}, {7'b0, got.last}, stamp);
    report_field("invalid", {7'b0, want.invalid}, {7'b0, got.invalid}, stamp);
  endfunction
endclass

module tb_utf8_confusable_skeleton_mapper_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ucsk_pkg::*;

  // Worst case is far below this: the limit only catches a hung run.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;

  // Every single-byte lookalike outside the fullwidth letter ranges.
  localparam logic [20:0] ALIAS_POINTS [61] = '{
    21'h0430, 21'h0410, 21'h0391, 21'h03B1, 21'h0432, 21'h0412, 21'h0392, 21'h03B2,
    21'h0441, 21'h0421, 21'h0435, 21'h0415, 21'h0395, 21'h03B5, 21'h043D, 21'h041D,
    21'h0397, 21'h03B7, 21'h0456, 21'h0406, 21'h0399, 21'h03B9, 21'h0458, 21'h0408,
    21'h043A, 21'h041A, 21'h039A, 21'h03BA, 21'h043C, 21'h041C, 21'h039C, 21'h03BC,
    21'h039D, 21'h03BD, 21'h043E, 21'h041E, 21'h039F, 21'h03BF, 21'h0440, 21'h0420,
    21'h03A1, 21'h03C1, 21'h0442, 21'h0422, 21'h03A4, 21'h03C4, 21'h0445, 21'h0425,
    21'h03A7, 21'h03C7, 21'h0443, 21'h0423, 21'h03A5, 21'h03C5, 21'h2010, 21'h2011,
    21'h2012, 21'h2013, 21'h2014, 21'h2212, 21'h0FF0D
  };

  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  skeleton_scoreboard board;
  logic [7:0]         name_bytes[$];
  int                 send_idle_pct = 22;
  int                 recv_idle_pct = 54;
  int                 counted_items = 0;
  int                 cycle_count   = 0;

  utf8_confusable_skeleton_mapper_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the result side at random; change only on the falling edge.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check each result transaction; sample before the edge's updates land.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      board.check_result(result, $time);
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_utf8_confusable_skeleton_mapper_unit: errors");
      $finish;
    end
  end

  // Offer one byte, hold it until the block takes it, then note it.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{in_byte: b, end_of_name: fin};
    @(posedge clk);
    while (item_stall) begin
      @(posedge clk);
    end
    if (board.note_byte(item)) begin
      counted_items++;
    end
    @(negedge clk);
  endtask

  // Send the staged identifier and mark its final byte.
  task automatic send_name();
    for (int i = 0; i < name_bytes.size(); i++) begin
      send_byte(name_bytes[i], i == name_bytes.size() - 1);
    end
  endtask

  // Add one byte to the end of the staged identifier.
  function automatic void append_name_byte(logic [7:0] b);
    name_bytes.insert(name_bytes.size(), b);
  endfunction

  // Append cp in a len-byte form; a len longer than needed gives an overlong form.
  function automatic void push_encoded(logic [20:0] cp, int unsigned len);
    case (len)
      1: append_name_byte({1'b0, cp[6:0]});
      2: begin
        append_name_byte({3'b110, cp[10:6]});
        append_name_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_name_byte({4'b1110, cp[15:12]});
        append_name_byte({2'b10, cp[11:6]});
        append_name_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_name_byte({5'b11110, cp[20:18]});
        append_name_byte({2'b10, cp[17:12]});
        append_name_byte({2'b10, cp[11:6]});
        append_name_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Stage a random identifier: mostly well-formed code points, some noise
  // bytes and cut-off sequences.
  function automatic void build_random_name();
    int unsigned n_cp;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    logic [20:0] cp;
    name_bytes.delete();
    n_cp = $urandom_range(1, 6);
    for (int unsigned i = 0; i < n_cp; i++) begin
      pick = $urandom_range(99);
      if (pick < 28) begin
        cp  = 21'($urandom_range(0, 127));
        len = ($urandom_range(9) == 0) ? 2 : 1;
        push_encoded(cp, len);
      end else if (pick < 48) begin
        // Cover both fullwidth letter ranges and the code points around them.
        if ($urandom_range(3) == 0) cp = 21'($urandom_range(21'h0FF1F, 21'h0FF5C));
        else                        cp = ALIAS_POINTS[$urandom_range(0, 60)];
        len = (cp < 21'h800) ? 2 : 3;
        if ($urandom_range(7) == 0) len++;
        push_encoded(cp, len);
      end else if (pick < 60) begin
        if ($urandom_range(1) == 0) cp = 21'($urandom_range(21'h370, 21'h45F));
        else                        cp = 21'($urandom_range(0, 21'h7FF));
        push_encoded(cp, 2);
      end else if (pick < 72) begin
        if ($urandom_range(3) == 0) cp = 21'($urandom_range(21'h2000, 21'h2220));
        else                        cp = 21'($urandom_range(0, 21'hFFFF));
        push_encoded(cp, 3);
      end else if (pick < 82) begin
        cp = 21'($urandom());
        push_encoded(cp, 4);
      end else if (pick < 90) begin
        append_name_byte(8'($urandom_range(0, 255)));
      end else begin
        // Drop the tail of a sequence so the next byte or the end breaks it.
        len = $urandom_range(2, 4);
        cp  = 21'($urandom());
        push_encoded(cp, len);
        cut = $urandom_range(1, len - 1);
        repeat (cut) void'(name_bytes.pop_back());
      end
    end
  endfunction

  initial begin
    board = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ASCII extremes, NUL and a folded digit.
    name_bytes = '{8'h00, 8'h41, 8'h5A, 8'h7F, 8'h30};
    send_name();
    // Cyrillic and fullwidth lookalikes, an overlong NUL and the largest
    // four-byte code point.
    name_bytes = '{8'hD0, 8'hB0, 8'hEF, 8'hBC, 8'hA1, 8'hC0, 8'h80,
                   8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_name();
    // Stray continuation, then a byte that must be dropped.
    name_bytes = '{8'h80, 8'h41};
    send_name();
    // Good byte first, then the error on the final byte itself.
    name_bytes = '{8'h62, 8'hF8};
    send_name();
    // Lead byte where a continuation belongs.
    name_bytes = '{8'hE2, 8'hC3};
    send_name();
    // Sequence cut off by the end of the identifier.
    name_bytes = '{8'hE2, 8'h80};
    send_name();

    // Sender idles less than the receiver.
    counted_items = 0;
    while (counted_items < 160) begin
      build_random_name();
      send_name();
    end
    // Swap the idle rates.
    send_idle_pct = 54;
    recv_idle_pct = 22;
    while (counted_items < 320) begin
      build_random_name();
      send_name();
    end
    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (counted_items < 480) begin
      build_random_name();
      send_name();
    end
    item_valid <= 1'b0;

    // Drain, then watch a little longer for stray results.
    while (board.expected_skeleton.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_utf8_confusable_skeleton_mapper_unit: clean");
    end else begin
      $display("tb_utf8_confusable_skeleton_mapper_unit: errors");
    end
    $finish;
  end
endmodule
